@@ hdl/sppq_pkg.sv @@
// Shared types and codes for the sorted priority queue unit.
// Used by the controller, the datapath and the top level; no dependencies.
package sppq_pkg;

    // Command codes carried in the input tuser field.
    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_POP       = 2'd1,
        CMD_PEEK_HEAD = 2'd2,
        CMD_PEEK_TAIL = 2'd3
    } cmd_t;

    // Result status codes carried in the output tuser field.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    localparam int ID_W   = 16;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int FILL_W = 4;

    // One queued job.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] exec_time;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    // Controller states.
    typedef enum logic {
        CTL_EMPTY,
        CTL_HOLD
    } ctl_state_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
        cmd_t op;
    } dp_cmd_t;

endpackage

@@ hdl/sppq_ctrl.sv @@
// Handshake controller for the sorted priority queue unit.
// Depends on sppq_pkg; drives the datapath through a dp_cmd_t.
module sppq_ctrl import sppq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    dp_cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        dp_cmd.op   = cmd_t'(s_tuser);
        dp_cmd.exec = 1'b0;
        case (state_reg)
            CTL_EMPTY: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.exec = 1'b1;
                    state_next  = CTL_HOLD;
                end
            end
            CTL_HOLD: begin
                // The result register frees up in the same cycle it is taken,
                // so a new item can be accepted alongside the handoff.
                m_tvalid = 1'b1;
                s_tready = m_tready;
                if (m_tready) begin
                    if (s_tvalid) begin
                        dp_cmd.exec = 1'b1;
                    end else begin
                        state_next = CTL_EMPTY;
                    end
                end
            end
            default: begin
                state_next = CTL_EMPTY;
            end
        endcase
    end

endmodule

@@ hdl/sppq_datapath.sv @@
// Slot array, fill count and result register of the sorted priority queue.
// Depends on sppq_pkg; commanded by sppq_ctrl.
module sppq_datapath import sppq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  dp_cmd,
    input  logic [ID_W-1:0]          in_id,
    input  logic [TIME_W-1:0]        in_time,
    input  logic [PRIO_W-1:0]        in_prio,
    output slot_t                    res_job,
    output status_t                  res_status,
    output logic [FILL_W-1:0]        res_fill
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    slot_t              slot_reg [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   count_dec;
    logic [IDX_W-1:0]   tail_idx;
    logic [DEPTH-1:0]   ge;
    logic               full;
    logic               empty;
    logic               do_push;
    logic               do_pop;
    slot_t              item;
    slot_t              res_job_next;
    status_t            res_status_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CNT_W'(1);
    assign tail_idx  = count_dec[IDX_W-1:0];
    assign item      = '{id: in_id, exec_time: in_time, prio: in_prio};
    assign do_push   = dp_cmd.exec && (dp_cmd.op == CMD_PUSH) && !full;
    assign do_pop    = dp_cmd.exec && (dp_cmd.op == CMD_POP) && !empty;

    // Each held slot whose priority is at least the new one keeps its place.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            ge[k] = (CNT_W'(k) < count_reg) && (slot_reg[k].prio >= in_prio);
        end
    end

    // One compare-and-shift cell per slot.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        slot_t slot_next;
        logic  ins_here;

        if (k == 0) begin : g_head
            assign ins_here = !ge[0];
        end else begin : g_body
            assign ins_here = !ge[k] && ge[k-1];
        end

        always_comb begin
            slot_next = slot_reg[k];
            if (do_push) begin
                if (ins_here) begin
                    slot_next = item;
                end else if (!ge[k]) begin
                    if (k > 0) begin
                        slot_next = slot_reg[(k > 0) ? k - 1 : 0];
                    end
                end
            end else if (do_pop) begin
                if (k < DEPTH - 1) begin
                    slot_next = slot_reg[(k < DEPTH - 1) ? k + 1 : k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (do_push || do_pop) begin
                slot_reg[k] <= slot_next;
            end
        end
    end

    always_comb begin
        count_next      = count_reg;
        res_job_next    = '0;
        res_status_next = ST_OK;
        case (dp_cmd.op)
            CMD_PUSH: begin
                if (full) begin
                    res_status_next = ST_OVERFLOW;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (empty) begin
                    res_status_next = ST_UNDERFLOW;
                end else begin
                    res_job_next = slot_reg[0];
                    count_next   = count_dec;
                end
            end
            CMD_PEEK_HEAD: begin
                if (empty) begin
                    res_status_next = ST_UNDERFLOW;
                end else begin
                    res_job_next = slot_reg[0];
                end
            end
            CMD_PEEK_TAIL: begin
                if (empty) begin
                    res_status_next = ST_UNDERFLOW;
                end else begin
                    res_job_next = slot_reg[tail_idx];
                end
            end
            default: begin
                res_status_next = ST_UNDERFLOW;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (dp_cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.exec) begin
            res_job    <= res_job_next;
            res_status <= res_status_next;
            res_fill   <= FILL_W'(count_next);
        end
    end

endmodule

@@ hdl/sorted_priority_queue_unit.sv @@
// A result item appears on the master side in the cycle after its command is accepted.
// Throughput: one item per cycle while m_tready stays high; the slot cells insert or remove an item in a single update.
// A held result does not block input: the next item is accepted in the cycle the result is taken.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
// Slot contents are not cleared by reset; only slots below the fill count are ever read.
module sorted_priority_queue_unit import sppq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: job_id[15:0], exec_time[31:16], job_priority[39:32]
    input  logic [39:0] s_tdata,
    // s_tuser: command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: out_id[15:0], out_time[31:16], out_priority[39:32],
    // fill_count[43:40], zero pad[47:44]
    output logic [47:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]  m_tuser
);

    dp_cmd_t           dp_cmd;
    slot_t             res_job;
    status_t           res_status;
    logic [FILL_W-1:0] res_fill;

    // The controller owns the handshake; the datapath holds the sorted slots,
    // the fill count and the result register.
    sppq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    sppq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dp_cmd     (dp_cmd),
        .in_id      (s_tdata[15:0]),
        .in_time    (s_tdata[31:16]),
        .in_prio    (s_tdata[39:32]),
        .res_job    (res_job),
        .res_status (res_status),
        .res_fill   (res_fill)
    );

    // Pack the result item; the job fields are zero for a push and on underflow.
    assign m_tdata = {4'd0, res_fill, res_job.prio, res_job.exec_time, res_job.id};
    assign m_tuser = res_status;

`ifndef SYNTHESIS
    localparam logic [FILL_W-1:0] FILL_AT_DEPTH = FILL_W'(DEPTH);

    // An accepted item always produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item did not produce a result");

    // An overflow can only be reported when the queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_OVERFLOW)) |-> (m_tdata[43:40] == FILL_AT_DEPTH))
        else $error("overflow reported with free slots");

    // An underflow reports an empty queue and zero job fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_UNDERFLOW)) |->
        ((m_tdata[43:40] == '0) && (m_tdata[39:0] == '0)))
        else $error("underflow result not empty or not zeroed");

    // A result that is taken without a new item leaves the output empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !s_tvalid) |=> !m_tvalid)
        else $error("result repeated after handoff");
`endif

endmodule

@@ tb/sorted_priority_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted priority queue unit: directed corner cases, then
// random push/pop/peek traffic under three source/sink stall mixes. Depends on sppq_pkg.
module sorted_priority_queue_unit_tb;
    import sppq_pkg::*;

    localparam int DEPTH = 8;

    // One expected result item, split into the fields carried on the master side.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] exec_time;
        logic [PRIO_W-1:0] prio;
        status_t           status;
        logic [FILL_W-1:0] fill;
    } queue_reply_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // job_id[15:0], exec_time[31:16], job_priority[39:32]
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_id, out_time, out_priority, fill_count, zero pad
    logic [1:0]  m_tuser;   // status[1:0]

    // Shadow copy of the queue contents, head at index 0.
    slot_t        shadow_jobs[$];
    queue_reply_t pending_replies[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int error_count   = 0;
    int stat_stored   = 0;
    int stat_overflow = 0;
    int stat_underflw = 0;
    int stat_returned = 0;

    sorted_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Applies one command to the shadow queue and returns the result it should produce.
    function automatic queue_reply_t apply_queue_command(cmd_t cmd, slot_t job);
        queue_reply_t reply;
        int pos;
        reply = '0;
        reply.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (shadow_jobs.size() >= DEPTH) begin
                reply.status = ST_OVERFLOW;
                stat_overflow++;
            end else begin
                // The new job lands behind every job of equal or higher priority.
                pos = 0;
                while (pos < shadow_jobs.size() && shadow_jobs[pos].prio >= job.prio)
                    pos++;
                shadow_jobs.insert(pos, job);
                stat_stored++;
            end
        end else if (shadow_jobs.size() == 0) begin
            reply.status = ST_UNDERFLOW;
            stat_underflw++;
        end else begin
            case (cmd)
                CMD_POP: begin
                    job = shadow_jobs.pop_front();
                end
                CMD_PEEK_HEAD: begin
                    job = shadow_jobs[0];
                end
                default: begin
                    job = shadow_jobs[shadow_jobs.size() - 1];
                end
            endcase
            reply.id        = job.id;
            reply.exec_time = job.exec_time;
            reply.prio      = job.prio;
            stat_returned++;
        end
        reply.fill = FILL_W'(shadow_jobs.size());
        return reply;
    endfunction

    // Presents one item after a random number of idle cycles and waits until it is taken.
    // The expected result is recorded at the edge where the item is accepted.
    task automatic send_command(cmd_t cmd, slot_t job);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {job.prio, job.exec_time, job.id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_replies.push_back(apply_queue_command(cmd, job));
    endtask

    // Sink side: random back-pressure, and every accepted result is compared with the
    // oldest expectation.
    always @(posedge aclk) begin
        queue_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result item: data %h, status %0d", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[15:0] !== want.id) begin
                    $error("out_id: expected %0h, actual %0h", want.id, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== want.exec_time) begin
                    $error("out_time: expected %0h, actual %0h", want.exec_time,
                           m_tdata[31:16]);
                    error_count++;
                end
                if (m_tdata[39:32] !== want.prio) begin
                    $error("out_priority: expected %0h, actual %0h", want.prio,
                           m_tdata[39:32]);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[43:40] !== want.fill) begin
                    $error("fill_count: expected %0d, actual %0d", want.fill,
                           m_tdata[43:40]);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Pop and both peeks on an empty queue must report underflow with zero job fields.
    task automatic test_empty_queue();
        slot_t noise;
        noise = slot_t'({$urandom, $urandom});
        send_command(CMD_POP, noise);
        send_command(CMD_PEEK_HEAD, noise);
        send_command(CMD_PEEK_TAIL, noise);
    endtask

    // All-zero and all-one jobs, then look at both ends.
    task automatic test_field_extremes();
        send_command(CMD_PUSH, '{id: 16'h0000, exec_time: 16'h0000, prio: 8'h00});
        send_command(CMD_PUSH, '{id: 16'hFFFF, exec_time: 16'hFFFF, prio: 8'hFF});
        send_command(CMD_PEEK_HEAD, '0);
        send_command(CMD_PEEK_TAIL, '1);
    endtask

    // Fill to capacity with ties on both sides of existing entries, push once more, then peek at the tail.
    task automatic test_fill_and_overflow();
        send_command(CMD_PUSH, '{id: 16'h0101, exec_time: 16'h1111, prio: 8'h80});
        send_command(CMD_PUSH, '{id: 16'h0202, exec_time: 16'h2222, prio: 8'h80});
        send_command(CMD_PUSH, '{id: 16'h0303, exec_time: 16'h3333, prio: 8'h80});
        send_command(CMD_PUSH, '{id: 16'h0404, exec_time: 16'h4444, prio: 8'h01});
        send_command(CMD_PUSH, '{id: 16'h0505, exec_time: 16'h5555, prio: 8'hFF});
        send_command(CMD_PUSH, '{id: 16'h0606, exec_time: 16'h6666, prio: 8'h00});
        send_command(CMD_PUSH, '{id: 16'hA5A5, exec_time: 16'h5A5A, prio: 8'hFF});
        send_command(CMD_PEEK_TAIL, '0);
    endtask

    // Pop everything out in service order, then pop once more from the empty queue.
    task automatic test_drain_order();
        repeat (DEPTH + 1)
            send_command(CMD_POP, slot_t'({$urandom, $urandom}));
    endtask

    // Bursts that lean toward filling, draining or a balance, so the queue keeps crossing
    // both the full and the empty boundary. Priorities often collide to exercise tie order.
    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        int    sent;
        int    burst_left;
        int    push_pct;
        cmd_t  cmd;
        slot_t job;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent       = 0;
        burst_left = 0;
        push_pct   = 50;
        while (sent < n_items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(24, 1);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 20;
                    default: push_pct = 55;
                endcase
            end
            if ($urandom_range(99) < push_pct) begin
                cmd = CMD_PUSH;
            end else begin
                case ($urandom_range(3))
                    0, 1: cmd = CMD_POP;
                    2: cmd = CMD_PEEK_HEAD;
                    default: cmd = CMD_PEEK_TAIL;
                endcase
            end
            job.id        = ID_W'($urandom);
            job.exec_time = TIME_W'($urandom);
            case ($urandom_range(2))
                0: job.prio = PRIO_W'($urandom);
                1: job.prio = PRIO_W'($urandom_range(3));
                default: job.prio = PRIO_W'($urandom_range(255, 252));
            endcase
            send_command(cmd, job);
            sent++;
            burst_left--;
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_PUSH;
        m_tready = 1'b0;
        aresetn  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_field_extremes();
        test_fill_and_overflow();
        test_drain_order();
        test_random_traffic(450, 12, 68);
        test_random_traffic(450, 68, 12);
        test_random_traffic(450, 0, 0);
        s_tvalid <= 1'b0;

        // Let every outstanding result come back, then give any stray output time to appear.
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Covered %0d stored pushes, %0d overflows, %0d underflows and %0d returned jobs",
                 stat_stored, stat_overflow, stat_underflw, stat_returned);
        $display("across directed corners and three stall mixes; %0d mismatches seen.",
                 error_count);
        if (error_count == 0) begin
            $display("sorted_priority_queue_unit: match");
        end else begin
            $display("sorted_priority_queue_unit: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("sorted_priority_queue_unit: mismatch");
        $finish;
    end

endmodule
